// ----- sv/mrq_pkg.sv -----
// ----------------------------------------------------------------------------
// mrq_pkg
// Shared types and constants of the message ring queue: the request and
// result records, status and opcode codes, register indexes and the
// command and status records between controller and datapath.
// ----------------------------------------------------------------------------
package mrq_pkg;

   localparam int WORD_W   = 64;
   localparam int BYTES_W  = 4;
   localparam int LEN_W    = 7;
   localparam int OCC_W    = 5;
   localparam int CNT_W    = 64;
   localparam int STATUS_W = 3;
   localparam int CSR_W    = 32;
   localparam int CSR_AW   = 3;

   localparam logic [LEN_W-1:0]   LEN_MAX    = 7'h7F;
   localparam logic [BYTES_W-1:0] WORD_BYTES = 4'd8;

   localparam logic OP_PUSH = 1'b0;
   localparam logic OP_POP  = 1'b1;

   localparam logic [STATUS_W-1:0] ST_PUSH_OK    = 3'd0;
   localparam logic [STATUS_W-1:0] ST_PUSH_FAIL  = 3'd1;
   localparam logic [STATUS_W-1:0] ST_POP_WORD   = 3'd2;
   localparam logic [STATUS_W-1:0] ST_POP_EMPTY  = 3'd3;
   localparam logic [STATUS_W-1:0] ST_POP_TOO_BIG = 3'd4;

   localparam logic CSR_MAX_PAYLOAD = 1'b0;
   localparam logic CSR_SLOTS_LOG2  = 1'b1;

   typedef struct packed {
      logic               opcode;
      logic [WORD_W-1:0]  push_word;
      logic [BYTES_W-1:0] push_bytes;
      logic               push_last;
      logic [LEN_W-1:0]   pop_capacity;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [WORD_W-1:0]   out_word;
      logic [BYTES_W-1:0]  out_bytes;
      logic                out_last;
      logic [LEN_W-1:0]    message_length;
      logic [OCC_W-1:0]    occupancy;
      logic [CNT_W-1:0]    failure_count;
   } rsp_type;

   typedef struct packed {
      logic push;
      logic pop_empty;
      logic len_read;
      logic pop_too_big;
      logic pop_zero;
      logic pop_start;
      logic word_step;
   } cmd_type;

   typedef struct packed {
      logic ring_empty;
      logic too_big;
      logic len_zero;
      logic word_last;
   } sts_type;

endpackage

// ----- sv/mrq_ram.sv -----
// ----------------------------------------------------------------------------
// mrq_ram
// Generic single-write, single-read memory with registered read data.
// ----------------------------------------------------------------------------
module mrq_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- sv/mrq_ctrl.sv -----
// ----------------------------------------------------------------------------
// mrq_ctrl
// Controller of the message ring queue: takes requests, sequences the
// length lookup and the word stream of a pop.
// ----------------------------------------------------------------------------
module mrq_ctrl
   import mrq_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  logic    opcode,
   input  sts_type sts,
   output cmd_type cmd,
   output logic    busy
);

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_LEN  = 3'b010,
      S_WORD = 3'b100
   } state_type;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      busy     = 1'b1;
      unique case (state_ff)
         S_IDLE: begin
            busy = 1'b0;
            if (start) begin
               if (opcode == OP_PUSH) begin
                  cmd.push = 1'b1;
               end else if (sts.ring_empty) begin
                  cmd.pop_empty = 1'b1;
               end else begin
                  cmd.len_read = 1'b1;
                  state_in     = S_LEN;
               end
            end
         end
         S_LEN: begin
            if (sts.too_big) begin
               cmd.pop_too_big = 1'b1;
               state_in        = S_IDLE;
            end else if (sts.len_zero) begin
               cmd.pop_zero = 1'b1;
               state_in     = S_IDLE;
            end else begin
               cmd.pop_start = 1'b1;
               state_in      = S_WORD;
            end
         end
         S_WORD: begin
            cmd.word_step = 1'b1;
            if (sts.word_last) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

// ----- sv/mrq_dp.sv -----
// ----------------------------------------------------------------------------
// mrq_dp
// Datapath of the message ring queue: cursors, push assembly, failure
// counter, configuration registers, payload and length memories and the
// result register.
// ----------------------------------------------------------------------------
module mrq_dp
   import mrq_pkg::*;
#(
   parameter int SLOTS          = 16,
   parameter int WORDS_PER_SLOT = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  cmd_type          cmd,
   output sts_type          sts,
   input  req_type          req_data,
   input  logic             csr_wr,
   input  logic             csr_idx,
   input  logic [CSR_W-1:0] csr_wdata,
   output logic [CSR_W-1:0] csr_rdata,
   output logic             rsp_valid,
   output rsp_type          rsp_data
);

   localparam int SLOT_W     = $clog2(SLOTS);
   localparam int CUR_W      = SLOT_W + 1;
   localparam int IDX_W      = $clog2(WORDS_PER_SLOT + 1);
   localparam int DEPTH      = SLOTS * WORDS_PER_SLOT;
   localparam int ADDR_W     = $clog2(DEPTH);
   localparam int SLOT_BYTES = 8 * WORDS_PER_SLOT;
   localparam int OW_W       = (CUR_W > OCC_W) ? CUR_W : OCC_W;

   // configuration
   logic [LEN_W-1:0] max_payload_ff, max_payload_in;
   logic [2:0]       slots_log2_ff, slots_log2_in;

   // ring state
   logic [CUR_W-1:0] wr_cursor_ff, wr_cursor_in;
   logic [CUR_W-1:0] rd_cursor_ff, rd_cursor_in;
   logic [CNT_W-1:0] fail_count_ff, fail_count_in;
   logic [LEN_W-1:0] pend_len_ff, pend_len_in;
   logic [IDX_W-1:0] pend_idx_ff, pend_idx_in;
   logic             full_start_ff, full_start_in;

   // pop context
   logic [LEN_W-1:0]  cap_ff, cap_in;
   logic [SLOT_W-1:0] rd_slot_ff, rd_slot_in;
   logic [LEN_W-1:0]  len_ff, len_in;
   logic [IDX_W-1:0]  nwords_ff, nwords_in;
   logic [IDX_W-1:0]  word_idx_ff, word_idx_in;

   // result
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;

   logic [2:0]         s_eff;
   logic [CUR_W-1:0]   nslots;
   logic [SLOT_W-1:0]  slot_mask;
   logic [CUR_W-1:0]   occ_now;
   logic               full_now;
   logic [SLOT_W-1:0]  wr_slot;
   logic [SLOT_W-1:0]  rd_slot;
   logic               fas;
   logic [LEN_W:0]     pend_sum8;
   logic [LEN_W:0]     pend_sum_last;
   logic [BYTES_W-1:0] pb_clip;
   logic [LEN_W-1:0]   push_len;
   logic [LEN_W-1:0]   eff_max;
   logic               push_ok;
   logic [CUR_W-1:0]   occ_diff;
   logic [OW_W-1:0]    occ_wide;

   logic              pl_wr_en;
   logic [ADDR_W-1:0] pl_wr_addr;
   logic              pl_rd_en;
   logic [ADDR_W-1:0] pl_rd_addr;
   logic [WORD_W-1:0] pl_rd_data;
   logic [ADDR_W-1:0] rd_base;
   logic              ln_wr_en;
   logic [LEN_W-1:0]  len_rd;

   logic [LEN_W:0]     nwords_raw;
   logic [IDX_W-1:0]   word_next;
   logic               word_last;
   logic [LEN_W:0]     rem;
   logic [BYTES_W-1:0] word_bytes;
   logic [WORD_W-1:0]  word_masked;

   function automatic logic [WORD_W-1:0] keep_bytes(input logic [WORD_W-1:0] w,
                                                    input logic [BYTES_W-1:0] n);
      logic [WORD_W-1:0] r;
      r = '0;
      for (int j = 0; j < 8; j++) begin
         if (BYTES_W'(j) < n) begin
            r[8*j +: 8] = w[8*j +: 8];
         end
      end
      return r;
   endfunction

   // slot geometry
   always_comb begin
      s_eff = (slots_log2_ff == 3'd0) ? 3'd1 : slots_log2_ff;
      if (int'(s_eff) >= SLOT_W) begin
         nslots = CUR_W'(SLOTS);
      end else begin
         nslots = CUR_W'(1) << s_eff;
      end
      slot_mask = SLOT_W'(nslots - 1'b1);
      occ_now   = wr_cursor_ff - rd_cursor_ff;
      full_now  = (occ_now >= nslots);
      wr_slot   = wr_cursor_ff[SLOT_W-1:0] & slot_mask;
      rd_slot   = rd_cursor_ff[SLOT_W-1:0] & slot_mask;
   end

   // push assembly
   always_comb begin
      fas           = (pend_idx_ff == '0) ? full_now : full_start_ff;
      pend_sum8     = {1'b0, pend_len_ff} + (LEN_W + 1)'(8);
      pb_clip       = (req_data.push_bytes > WORD_BYTES) ? WORD_BYTES : req_data.push_bytes;
      pend_sum_last = {1'b0, pend_len_ff} + (LEN_W + 1)'(pb_clip);
      push_len      = (pend_sum_last > {1'b0, LEN_MAX}) ? LEN_MAX : pend_sum_last[LEN_W-1:0];
      if (int'(max_payload_ff) > SLOT_BYTES) begin
         eff_max = LEN_W'(SLOT_BYTES);
      end else begin
         eff_max = max_payload_ff;
      end
      push_ok    = !fas && (push_len <= eff_max);
      pl_wr_en   = cmd.push && !fas && (int'(pend_idx_ff) < WORDS_PER_SLOT);
      pl_wr_addr = ADDR_W'(wr_slot * WORDS_PER_SLOT) + ADDR_W'(pend_idx_ff);
      ln_wr_en   = cmd.push && req_data.push_last && push_ok;
   end

   // pop word stream
   always_comb begin
      nwords_raw = ({1'b0, len_rd} + (LEN_W + 1)'(7)) >> 3;
      if (int'(nwords_raw) > WORDS_PER_SLOT) begin
         nwords_in = IDX_W'(WORDS_PER_SLOT);
      end else begin
         nwords_in = IDX_W'(nwords_raw);
      end
      word_next  = word_idx_ff + 1'b1;
      word_last  = (word_next == nwords_ff);
      rem        = {1'b0, len_ff} - (LEN_W + 1)'({word_idx_ff, 3'b000});
      if (!word_last || rem > (LEN_W + 1)'(WORD_BYTES)) begin
         word_bytes = WORD_BYTES;
      end else begin
         word_bytes = BYTES_W'(rem);
      end
      word_masked = keep_bytes(pl_rd_data, word_bytes);
      rd_base     = ADDR_W'(rd_slot_ff * WORDS_PER_SLOT);
      pl_rd_en    = cmd.pop_start || (cmd.word_step && !word_last);
      pl_rd_addr  = cmd.pop_start ? rd_base : rd_base + ADDR_W'(word_next);
   end

   always_comb begin
      sts.ring_empty = (occ_now == '0);
      sts.too_big    = (len_rd > cap_ff);
      sts.len_zero   = (len_rd == '0);
      sts.word_last  = word_last;
   end

   // state update
   always_comb begin
      wr_cursor_in  = wr_cursor_ff;
      rd_cursor_in  = rd_cursor_ff;
      fail_count_in = fail_count_ff;
      pend_len_in   = pend_len_ff;
      pend_idx_in   = pend_idx_ff;
      full_start_in = full_start_ff;
      cap_in        = cap_ff;
      rd_slot_in    = rd_slot_ff;
      len_in        = len_ff;
      word_idx_in   = word_idx_ff;

      if (cmd.push) begin
         if (req_data.push_last) begin
            pend_len_in   = '0;
            pend_idx_in   = '0;
            full_start_in = 1'b0;
            if (push_ok) begin
               wr_cursor_in = wr_cursor_ff + 1'b1;
            end else begin
               fail_count_in = fail_count_ff + 1'b1;
            end
         end else begin
            pend_len_in   = (pend_sum8 > {1'b0, LEN_MAX}) ? LEN_MAX : pend_sum8[LEN_W-1:0];
            full_start_in = fas;
            if (int'(pend_idx_ff) < WORDS_PER_SLOT) begin
               pend_idx_in = pend_idx_ff + 1'b1;
            end
         end
      end
      if (cmd.len_read) begin
         cap_in     = req_data.pop_capacity;
         rd_slot_in = rd_slot;
      end
      if (cmd.pop_start || cmd.pop_zero) begin
         rd_cursor_in = rd_cursor_ff + 1'b1;
      end
      if (cmd.pop_start) begin
         len_in      = len_rd;
         word_idx_in = '0;
      end
      if (cmd.word_step) begin
         word_idx_in = word_next;
      end
   end

   // result record
   always_comb begin
      occ_diff     = wr_cursor_in - rd_cursor_in;
      occ_wide     = OW_W'(occ_diff);
      rsp_valid_in = (cmd.push && req_data.push_last) || cmd.pop_empty ||
                     cmd.pop_too_big || cmd.pop_zero || cmd.word_step;
      rsp_in                = '0;
      rsp_in.out_last       = 1'b1;
      rsp_in.occupancy      = occ_wide[OCC_W-1:0];
      rsp_in.failure_count  = fail_count_in;
      if (cmd.push) begin
         rsp_in.status         = push_ok ? ST_PUSH_OK : ST_PUSH_FAIL;
         rsp_in.message_length = push_len;
      end else if (cmd.pop_empty) begin
         rsp_in.status = ST_POP_EMPTY;
      end else if (cmd.pop_too_big) begin
         rsp_in.status         = ST_POP_TOO_BIG;
         rsp_in.message_length = len_rd;
      end else if (cmd.pop_zero) begin
         rsp_in.status = ST_POP_WORD;
      end else if (cmd.word_step) begin
         rsp_in.status         = ST_POP_WORD;
         rsp_in.out_word       = word_masked;
         rsp_in.out_bytes      = word_bytes;
         rsp_in.out_last       = word_last;
         rsp_in.message_length = len_ff;
      end
   end

   // configuration registers
   always_comb begin
      max_payload_in = max_payload_ff;
      slots_log2_in  = slots_log2_ff;
      csr_rdata      = '0;
      unique case (csr_idx)
         CSR_MAX_PAYLOAD: begin
            csr_rdata = CSR_W'(max_payload_ff);
            if (csr_wr) begin
               max_payload_in = csr_wdata[LEN_W-1:0];
            end
         end
         CSR_SLOTS_LOG2: begin
            csr_rdata = CSR_W'(slots_log2_ff);
            if (csr_wr) begin
               slots_log2_in = csr_wdata[2:0];
            end
         end
         default: begin
            csr_rdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_payload_ff <= 7'd64;
         slots_log2_ff  <= 3'd4;
         wr_cursor_ff   <= '0;
         rd_cursor_ff   <= '0;
         fail_count_ff  <= '0;
         pend_len_ff    <= '0;
         pend_idx_ff    <= '0;
         full_start_ff  <= 1'b0;
         word_idx_ff    <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         max_payload_ff <= max_payload_in;
         slots_log2_ff  <= slots_log2_in;
         wr_cursor_ff   <= wr_cursor_in;
         rd_cursor_ff   <= rd_cursor_in;
         fail_count_ff  <= fail_count_in;
         pend_len_ff    <= pend_len_in;
         pend_idx_ff    <= pend_idx_in;
         full_start_ff  <= full_start_in;
         word_idx_ff    <= word_idx_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cap_ff     <= cap_in;
      rd_slot_ff <= rd_slot_in;
      len_ff     <= len_in;
      if (cmd.pop_start) begin
         nwords_ff <= nwords_in;
      end
      rsp_ff     <= rsp_in;
   end

   mrq_ram #(
      .WIDTH (WORD_W),
      .DEPTH (DEPTH)
   ) u_payload_ram (
      .clock   (clock),
      .wr_en   (pl_wr_en),
      .wr_addr (pl_wr_addr),
      .wr_data (req_data.push_word),
      .rd_en   (pl_rd_en),
      .rd_addr (pl_rd_addr),
      .rd_data (pl_rd_data)
   );

   mrq_ram #(
      .WIDTH (LEN_W),
      .DEPTH (SLOTS)
   ) u_length_ram (
      .clock   (clock),
      .wr_en   (ln_wr_en),
      .wr_addr (wr_slot),
      .wr_data (push_len),
      .rd_en   (cmd.len_read),
      .rd_addr (rd_slot),
      .rd_data (len_rd)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ----- sv/message_ring_queue.sv -----
// ----------------------------------------------------------------------------
// message_ring_queue
// Ring queue of variable-length messages held in SLOTS slots of
// WORDS_PER_SLOT 64-bit words, with push, pop and a failure counter.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. A push takes one
// word per cycle with busy staying low, and the last word of a message
// gives its accept or reject result in the next cycle. A pop of an empty
// ring answers in the cycle after it is taken and keeps busy low. Any other
// pop holds busy high for the registered read of the length memory; a
// too-large or a zero-length message answers right after it, while a
// streamed message holds busy until its last word, one word per cycle from
// the registered read of the payload memory. Results come one per cycle
// with rsp_valid and must be taken as they appear; out_last marks the last
// result of a request. Configuration is written through the APB port; the
// user must write it only while idle, as the block does not enforce this.
module message_ring_queue
   import mrq_pkg::*;
#(
   parameter int SLOTS          = 16,
   parameter int WORDS_PER_SLOT = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  req_type           req_data,
   output logic              rsp_valid,
   output rsp_type           rsp_data,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [CSR_AW-1:0] paddr,
   input  logic [CSR_W-1:0]  pwdata,
   output logic [CSR_W-1:0]  prdata,
   output logic              pready
);

   cmd_type cmd;
   sts_type sts;
   logic    csr_wr;

   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite;

   mrq_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .opcode (req_data.opcode),
      .sts    (sts),
      .cmd    (cmd),
      .busy   (busy)
   );

   mrq_dp #(
      .SLOTS          (SLOTS),
      .WORDS_PER_SLOT (WORDS_PER_SLOT)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .sts       (sts),
      .req_data  (req_data),
      .csr_wr    (csr_wr),
      .csr_idx   (paddr[2]),
      .csr_wdata (pwdata),
      .csr_rdata (prdata),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

// ----- sv/mrq_checker.sv -----
// ----------------------------------------------------------------------------
// mrq_checker
// Port-level checks of the message ring queue result stream.
// ----------------------------------------------------------------------------
module mrq_checker
   import mrq_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    rsp_valid,
   input rsp_type rsp_data
);

   // a word transfer that is not last is followed at once by the next one
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.out_last |=> rsp_valid)
      else $error("result stream broken before its last word");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != ST_POP_WORD |->
         rsp_data.out_word == '0 && rsp_data.out_bytes == '0 && rsp_data.out_last)
      else $error("non-word result carries word data");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == ST_POP_WORD && !rsp_data.out_last |->
         rsp_data.out_bytes == WORD_BYTES)
      else $error("inner word of a message is not full");

   // failure count moves only with a rejected push
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && $past(rsp_valid) && rsp_data.status != ST_PUSH_FAIL |->
         rsp_data.failure_count == $past(rsp_data.failure_count))
      else $error("failure count changed without a rejected push");

endmodule

bind message_ring_queue mrq_checker u_mrq_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);

// ----- bench/tb_message_ring_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_message_ring_queue
// Self-checking bench for the message ring queue. A directed table covers
// empty pops, zero-length and full-size messages, overlong and oversize
// pushes, too-large pops, pops in the middle of a push and a full ring.
// Random phases then sweep the payload limit and slot count with mostly
// well-formed messages, mixed pops and noise. Every accepted request runs
// through a prediction of the ring, and each result is
// compared field by field with the oldest prediction still due.
// ----------------------------------------------------------------------------
module tb_message_ring_queue;
   import mrq_pkg::*;

   localparam int SLOTS          = 16;
   localparam int WORDS_PER_SLOT = 8;
   localparam int SLOT_BYTES     = 8 * WORDS_PER_SLOT;
   localparam int CYCLE_LIMIT    = 400000;
   localparam int PHASES         = 8;
   localparam int PHASE_ITEMS    = 36;

   localparam logic [PHASES-1:0][LEN_W-1:0] PAYLOAD_PLAN =
      {7'd64, 7'd9, 7'd37, 7'd64, 7'd20, 7'd0, 7'd127, 7'd1};
   localparam logic [PHASES-1:0][2:0] SLOTS_PLAN =
      {3'd4, 3'd1, 3'd5, 3'd3, 3'd7, 3'd2, 3'd0, 3'd1};
   localparam logic [PHASES-1:0][3:0] IDLE_PLAN =
      {4'd0, 4'd5, 4'd10, 4'd4, 4'd8, 4'd0, 4'd3, 4'd6};

   typedef struct {
      req_type cmd;
      int      reps;
      logic    typed;
      rsp_type want;
   } plan_row_type;

   logic              clock = 1'b0;
   logic              reset;
   logic              start;
   logic              busy;
   req_type           req_data;
   logic              rsp_valid;
   rsp_type           rsp_data;
   logic              psel;
   logic              penable;
   logic              pwrite;
   logic [CSR_AW-1:0] paddr;
   logic [CSR_W-1:0]  pwdata;
   logic [CSR_W-1:0]  prdata;
   logic              pready;

   // predicted ring state
   logic [WORD_W-1:0] ring_words [SLOTS*WORDS_PER_SLOT];
   logic [LEN_W-1:0]  ring_lens [SLOTS];
   logic [OCC_W-1:0]  wr_cur;
   logic [OCC_W-1:0]  rd_cur;
   logic [CNT_W-1:0]  reject_total;
   int                pend_len;
   int                word_idx;
   logic              full_at_first;
   logic [LEN_W-1:0]  lim_payload;
   logic [2:0]        slot_sel;

   rsp_type      due_replies[$];
   rsp_type      head_reply;
   logic         typed_on;
   rsp_type      typed_want;
   plan_row_type plan[$];
   int           errors = 0;
   int           cycles = 0;
   int           sent = 0;
   int           idle_odds = 0;

   message_ring_queue #(
      .SLOTS(SLOTS),
      .WORDS_PER_SLOT(WORDS_PER_SLOT)
   ) uut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_data(rsp_data),
      .psel(psel),
      .penable(penable),
      .pwrite(pwrite),
      .paddr(paddr),
      .pwdata(pwdata),
      .prdata(prdata),
      .pready(pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [OCC_W-1:0] ring_fill();
      return wr_cur - rd_cur;
   endfunction

   function automatic int live_slots();
      int s;
      int n;
      s = int'(slot_sel);
      if (s < 1) s = 1;
      n = 1 << s;
      if (n > SLOTS) n = SLOTS;
      return n;
   endfunction

   function automatic rsp_type make_rsp(input logic [STATUS_W-1:0] st,
                                        input logic [WORD_W-1:0] w,
                                        input logic [BYTES_W-1:0] nb,
                                        input logic lst,
                                        input logic [LEN_W-1:0] len,
                                        input logic [OCC_W-1:0] occ,
                                        input logic [CNT_W-1:0] fails);
      rsp_type o;
      o.status         = st;
      o.out_word       = w;
      o.out_bytes      = nb;
      o.out_last       = lst;
      o.message_length = len;
      o.occupancy      = occ;
      o.failure_count  = fails;
      return o;
   endfunction

   function automatic req_type push_req(input logic [WORD_W-1:0] w,
                                        input logic [BYTES_W-1:0] nb,
                                        input logic lst);
      req_type r;
      r.opcode       = OP_PUSH;
      r.push_word    = w;
      r.push_bytes   = nb;
      r.push_last    = lst;
      r.pop_capacity = '0;
      return r;
   endfunction

   function automatic req_type pop_req(input logic [LEN_W-1:0] cap);
      req_type r;
      r.opcode       = OP_POP;
      r.push_word    = {$urandom, $urandom};
      r.push_bytes   = BYTES_W'($urandom_range(0, 15));
      r.push_last    = 1'($urandom_range(0, 1));
      r.pop_capacity = cap;
      return r;
   endfunction

   function automatic logic [LEN_W-1:0] pick_capacity();
      if ($urandom_range(0, 4) < 3) return LEN_W'($urandom_range(64, 127));
      return LEN_W'($urandom_range(0, 127));
   endfunction

   // expected results of one accepted request, in order
   task automatic apply_ring_op(input req_type r);
      int                nslots;
      int                slot;
      int                len;
      int                nwords;
      int                nb;
      int                cap;
      int                lim;
      logic              accept;
      logic [WORD_W-1:0] mask;
      nslots = live_slots();
      cap = int'(r.pop_capacity);
      lim = (int'(lim_payload) > SLOT_BYTES) ? SLOT_BYTES : int'(lim_payload);
      if (r.opcode == OP_PUSH) begin
         slot = int'(wr_cur) & (nslots - 1);
         if (word_idx == 0) full_at_first = (int'(ring_fill()) >= nslots);
         if (!full_at_first && word_idx < WORDS_PER_SLOT)
            ring_words[slot*WORDS_PER_SLOT + word_idx] = r.push_word;
         if (word_idx < WORDS_PER_SLOT) word_idx++;
         if (!r.push_last) begin
            pend_len = (pend_len + 8 > 127) ? 127 : pend_len + 8;
         end else begin
            nb = (r.push_bytes > 8) ? 8 : int'(r.push_bytes);
            len = (pend_len + nb > 127) ? 127 : pend_len + nb;
            accept = !full_at_first && len <= lim;
            if (accept) begin
               ring_lens[slot] = LEN_W'(len);
               wr_cur++;
            end else begin
               reject_total++;
            end
            pend_len = 0;
            word_idx = 0;
            full_at_first = 1'b0;
            due_replies.push_back(make_rsp(accept ? ST_PUSH_OK : ST_PUSH_FAIL, '0, '0,
                                           1'b1, LEN_W'(len), ring_fill(), reject_total));
         end
      end else if (ring_fill() == 0) begin
         due_replies.push_back(make_rsp(ST_POP_EMPTY, '0, '0, 1'b1, '0, ring_fill(),
                                        reject_total));
      end else begin
         slot = int'(rd_cur) & (nslots - 1);
         len = int'(ring_lens[slot]);
         if (len > cap) begin
            due_replies.push_back(make_rsp(ST_POP_TOO_BIG, '0, '0, 1'b1, LEN_W'(len),
                                           ring_fill(), reject_total));
         end else begin
            rd_cur++;
            if (len == 0) begin
               due_replies.push_back(make_rsp(ST_POP_WORD, '0, '0, 1'b1, '0,
                                              ring_fill(), reject_total));
            end else begin
               nwords = (len + 7) / 8;
               if (nwords > WORDS_PER_SLOT) nwords = WORDS_PER_SLOT;
               for (int i = 0; i < nwords; i++) begin
                  nb = (i == nwords - 1) ? len - 8*i : 8;
                  if (nb > 8) nb = 8;
                  mask = (nb == 8) ? '1 : ((64'd1 << (8*nb)) - 64'd1);
                  due_replies.push_back(make_rsp(ST_POP_WORD,
                                                 ring_words[slot*WORDS_PER_SLOT + i] & mask,
                                                 BYTES_W'(nb), i == nwords - 1,
                                                 LEN_W'(len), ring_fill(), reject_total));
               end
            end
         end
      end
   endtask

   task automatic check_field(input string what, input logic [63:0] want,
                              input logic [63:0] got);
      if (got !== want) begin
         $display("%0t %s mismatch: expected %h, got %h", $time, what, want, got);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid) begin
            if (due_replies.size() == 0) begin
               $display("%0t unexpected result: expected none, got %h", $time, rsp_data);
               errors++;
            end else begin
               head_reply = due_replies.pop_front();
               check_field("status", 64'(head_reply.status), 64'(rsp_data.status));
               check_field("out_word", head_reply.out_word, rsp_data.out_word);
               check_field("out_bytes", 64'(head_reply.out_bytes), 64'(rsp_data.out_bytes));
               check_field("out_last", 64'(head_reply.out_last), 64'(rsp_data.out_last));
               check_field("message_length", 64'(head_reply.message_length),
                           64'(rsp_data.message_length));
               check_field("occupancy", 64'(head_reply.occupancy),
                           64'(rsp_data.occupancy));
               check_field("failure_count", head_reply.failure_count,
                           rsp_data.failure_count);
            end
         end
         if (psel && penable && pwrite && pready && paddr[1:0] == 2'b00) begin
            if (paddr[2] == CSR_MAX_PAYLOAD) lim_payload = pwdata[LEN_W-1:0];
            else slot_sel = pwdata[2:0];
         end
         if (start && !busy) begin
            apply_ring_op(req_data);
            if (typed_on) due_replies[due_replies.size()-1] = typed_want;
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // returns at the falling edge after the transfer, start still high
   task automatic send_item(input req_type r, input logic typed, input rsp_type want);
      start = 1'b1;
      req_data = r;
      typed_on = typed;
      typed_want = want;
      @(posedge clock);
      while (busy !== 1'b0) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic hold_off(input int n);
      start = 1'b0;
      repeat (n) @(negedge clock);
   endtask

   task automatic settle_out(input int extra);
      start = 1'b0;
      while (due_replies.size() != 0) @(negedge clock);
      repeat (extra) @(negedge clock);
   endtask

   task automatic issue(input req_type r);
      if (idle_odds != 0 && $urandom_range(0, idle_odds - 1) == 0)
         hold_off(int'($urandom_range(1, 17)));
      send_item(r, 1'b0, '0);
      sent++;
      if (idle_odds != 0 && $urandom_range(0, 59) == 0) settle_out(0);
   endtask

   task automatic write_csr(input logic idx, input logic [LEN_W-1:0] val);
      psel = 1'b1;
      penable = 1'b0;
      pwrite = 1'b1;
      paddr = {idx, 2'b00};
      pwdata = $urandom;
      pwdata[LEN_W-1:0] = val;
      @(negedge clock);
      penable = 1'b1;
      @(posedge clock);
      while (pready !== 1'b1) @(posedge clock);
      @(negedge clock);
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
   endtask

   task automatic send_message();
      int      nwords;
      int      lim;
      req_type r;
      lim = (int'(lim_payload) > SLOT_BYTES) ? SLOT_BYTES : int'(lim_payload);
      nwords = ($urandom_range(0, 11) == 0) ? int'($urandom_range(9, 18))
                                            : int'($urandom_range(1, lim/8 + 1));
      for (int i = 0; i < nwords; i++) begin
         r.opcode       = OP_PUSH;
         r.push_word    = {$urandom, $urandom};
         r.push_bytes   = BYTES_W'($urandom_range(0, 15));
         r.push_last    = (i == nwords - 1);
         r.pop_capacity = LEN_W'($urandom_range(0, 127));
         if (r.push_last && $urandom_range(0, 6) != 0)
            r.push_bytes = BYTES_W'($urandom_range(1, 8));
         issue(r);
         if (!r.push_last && $urandom_range(0, 5) == 0) issue(pop_req(pick_capacity()));
      end
   endtask

   task automatic plan_step(input req_type c, input int n, input logic t, input rsp_type w);
      plan_row_type row;
      row.cmd = c;
      row.reps = n;
      row.typed = t;
      row.want = w;
      plan.push_back(row);
   endtask

   initial begin
      req_type r;
      int      pick;
      int      phase_base;
      reset = 1'b1;
      start = 1'b0;
      req_data = '0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      typed_on = 1'b0;
      typed_want = '0;
      foreach (ring_words[i]) ring_words[i] = '0;
      foreach (ring_lens[i]) ring_lens[i] = '0;
      wr_cur = '0;
      rd_cur = '0;
      reject_total = '0;
      pend_len = 0;
      word_idx = 0;
      full_at_first = 1'b0;
      lim_payload = 7'd64;
      slot_sel = 3'd4;

      plan_step(pop_req(7'd64), 1, 1'b1,
                make_rsp(ST_POP_EMPTY, '0, '0, 1'b1, 7'd0, 5'd0, 64'd0));
      plan_step(push_req(64'h0, 4'd0, 1'b1), 1, 1'b1,
                make_rsp(ST_PUSH_OK, '0, '0, 1'b1, 7'd0, 5'd1, 64'd0));
      plan_step(pop_req(7'd0), 1, 1'b1,
                make_rsp(ST_POP_WORD, '0, '0, 1'b1, 7'd0, 5'd0, 64'd0));
      plan_step(push_req('1, 4'd8, 1'b1), 1, 1'b1,
                make_rsp(ST_PUSH_OK, '0, '0, 1'b1, 7'd8, 5'd1, 64'd0));
      plan_step(pop_req(7'd7), 1, 1'b1,
                make_rsp(ST_POP_TOO_BIG, '0, '0, 1'b1, 7'd8, 5'd1, 64'd0));
      plan_step(pop_req(7'd8), 1, 1'b0, '0);
      plan_step(push_req(64'h0123_4567_89AB_CDEF, 4'd8, 1'b0), 7, 1'b0, '0);
      plan_step(push_req(64'hFEDC_BA98_7654_3210, 4'd15, 1'b1), 1, 1'b1,
                make_rsp(ST_PUSH_OK, '0, '0, 1'b1, 7'd64, 5'd1, 64'd0));
      plan_step(pop_req(7'd127), 1, 1'b0, '0);
      // overlong push, pending length saturates
      plan_step(push_req(64'hC3C3_0000_FFFF_3C3C, 4'd8, 1'b0), 16, 1'b0, '0);
      plan_step(push_req(64'h0F0F_0F0F_0F0F_0F0F, 4'd3, 1'b1), 1, 1'b1,
                make_rsp(ST_PUSH_FAIL, '0, '0, 1'b1, 7'd127, 5'd0, 64'd1));
      plan_step(push_req(64'h8000_0000_0000_0001, 4'd8, 1'b0), 1, 1'b0, '0);
      plan_step(push_req(64'h7FFF_FFFF_FFFF_FFFE, 4'd0, 1'b1), 1, 1'b1,
                make_rsp(ST_PUSH_OK, '0, '0, 1'b1, 7'd8, 5'd1, 64'd1));
      // pop in the middle of a push
      plan_step(push_req(64'hDEAD_BEEF_0BAD_F00D, 4'd8, 1'b0), 1, 1'b0, '0);
      plan_step(pop_req(7'd64), 1, 1'b0, '0);
      plan_step(push_req(64'h1122_3344_5566_7788, 4'd5, 1'b1), 1, 1'b1,
                make_rsp(ST_PUSH_OK, '0, '0, 1'b1, 7'd13, 5'd1, 64'd1));
      plan_step(pop_req(7'd12), 1, 1'b1,
                make_rsp(ST_POP_TOO_BIG, '0, '0, 1'b1, 7'd13, 5'd1, 64'd1));
      plan_step(pop_req(7'd13), 1, 1'b0, '0);
      plan_step(push_req(64'hA5A5_A5A5_A5A5_A5A5, 4'd8, 1'b0), 8, 1'b0, '0);
      plan_step(push_req(64'h5A5A_5A5A_5A5A_5A5A, 4'd0, 1'b1), 1, 1'b1,
                make_rsp(ST_PUSH_OK, '0, '0, 1'b1, 7'd64, 5'd1, 64'd1));
      plan_step(push_req(64'h3C3C_3C3C_3C3C_3C3C, 4'd8, 1'b0), 8, 1'b0, '0);
      plan_step(push_req('1, 4'd1, 1'b1), 1, 1'b1,
                make_rsp(ST_PUSH_FAIL, '0, '0, 1'b1, 7'd65, 5'd1, 64'd2));
      plan_step(pop_req(7'd64), 1, 1'b0, '0);
      // fill every slot, then a push that finds the ring full
      plan_step(push_req(64'h0000_00FF_0000_00FF, 4'd1, 1'b1), 16, 1'b0, '0);
      plan_step(push_req(64'h6666_7777_8888_9999, 4'd8, 1'b0), 1, 1'b0, '0);
      plan_step(push_req(64'h1234_5678_9ABC_DEF0, 4'd2, 1'b1), 1, 1'b1,
                make_rsp(ST_PUSH_FAIL, '0, '0, 1'b1, 7'd10, 5'd16, 64'd3));
      plan_step(pop_req(7'd127), 16, 1'b0, '0);
      plan_step(pop_req(7'd0), 1, 1'b1,
                make_rsp(ST_POP_EMPTY, '0, '0, 1'b1, 7'd0, 5'd0, 64'd3));

      repeat (10) @(negedge clock);
      reset = 1'b0;

      foreach (plan[n]) begin
         for (int k = 0; k < plan[n].reps; k++) begin
            r = plan[n].cmd;
            if (r.opcode == OP_PUSH) r.push_word = r.push_word + WORD_W'(k);
            send_item(r, plan[n].typed, plan[n].want);
         end
      end

      for (int p = 0; p < PHASES; p++) begin
         if (word_idx != 0) send_item(push_req({$urandom, $urandom},
                                               BYTES_W'($urandom_range(0, 15)), 1'b1),
                                      1'b0, '0);
         while (ring_fill() != 0) send_item(pop_req(7'd127), 1'b0, '0);
         settle_out(4);
         write_csr(CSR_MAX_PAYLOAD, PAYLOAD_PLAN[p]);
         write_csr(CSR_SLOTS_LOG2, LEN_W'(SLOTS_PLAN[p]));
         idle_odds = int'(IDLE_PLAN[p]);
         phase_base = sent;
         while (sent - phase_base < PHASE_ITEMS) begin
            pick = int'($urandom_range(0, 99));
            if (pick < ((p % 2 == 1) ? 60 : 40)) begin
               send_message();
            end else if (pick < 92) begin
               issue(pop_req(pick_capacity()));
            end else begin
               r.opcode       = 1'($urandom_range(0, 1));
               r.push_word    = {$urandom, $urandom};
               r.push_bytes   = BYTES_W'($urandom_range(0, 15));
               r.push_last    = 1'($urandom_range(0, 1));
               r.pop_capacity = LEN_W'($urandom_range(0, 127));
               issue(r);
            end
         end
      end

      settle_out(20);
      if (errors == 0) $display("ALL CHECKS PASSED");
      else $display("CHECKS FAILED");
      $finish;
   end

endmodule
